@@ rtl/bsst_pkg.sv @@
`timescale 1ns / 1ps

package bsst_pkg;

    localparam int unsigned TIMER_W = 10;
    localparam int unsigned PULSE_W = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 10'd300;
    localparam logic [PULSE_W-1:0] PULSE_LO_RST = 16'd500;
    localparam logic [PULSE_W-1:0] PULSE_HI_RST = 16'd2500;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HI = 2'd2;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_BTN1 = 2'd1;
    localparam logic [1:0] CMD_BTN2 = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic LEVEL_PRESSED = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_B1_DOWN = 3'd1,
        ST_B1_UP = 3'd2,
        ST_B2_DOWN = 3'd3,
        ST_B2_UP = 3'd4,
        ST_B1_DOWN_AGAIN = 3'd5,
        ST_COMPLETE = 3'd6
    } seq_state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       pin_level;
    } bsst_in_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic [2:0]         seq_state;
        logic               moved;
    } bsst_out_t;

endpackage

@@ rtl/button_sequence_servo_toggle_core.sv @@
`timescale 1ns / 1ps

// Servo toggle on a button sequence: press/release button 1, press/release button 2,
// press/release button 1, all within timeout_ticks ticks of the first press. The next tick
// after a complete sequence swaps the pulse width between its low and high end positions.
// Every input transaction yields exactly one result transaction carrying the pulse width, the
// sequence state after the event and a moved flag. An input is taken while the output register
// is empty or being taken; the sequence registers update in the accept cycle and the result sits
// in a single output register, so a new transaction is accepted while the previous one is taken.
// Throughput is one transaction per cycle while m_ready holds. Configuration writes take effect
// at the next edge. Users must apply them only while no transaction is in flight; not enforced.
module button_sequence_servo_toggle_core
    import bsst_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bsst_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bsst_out_t             m_data
);

    logic [TIMER_W-1:0] timeout_ticks_reg;
    logic [PULSE_W-1:0] pulse_lo_reg;
    logic [PULSE_W-1:0] pulse_hi_reg;

    seq_state_t         seq_reg, seq_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               at_max_reg, at_max_next;
    logic               b1_press_reg, b1_press_next;
    logic               b2_press_reg, b2_press_next;
    logic               moved_next;

    logic               m_valid_reg;
    bsst_out_t          m_data_reg, m_data_next;
    logic               accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RST;
            pulse_lo_reg      <= PULSE_LO_RST;
            pulse_hi_reg      <= PULSE_HI_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TIMEOUT:  timeout_ticks_reg <= cfg_wdata[TIMER_W-1:0];
                REG_PULSE_LO: pulse_lo_reg      <= cfg_wdata[PULSE_W-1:0];
                REG_PULSE_HI: pulse_hi_reg      <= cfg_wdata[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        seq_next      = seq_reg;
        timer_next    = timer_reg;
        at_max_next   = at_max_reg;
        b1_press_next = b1_press_reg;
        b2_press_next = b2_press_reg;
        moved_next    = 1'b0;
        unique case (s_data.cmd)
            CMD_TICK: begin
                if (seq_reg == ST_COMPLETE) begin
                    at_max_next = !at_max_reg;
                    seq_next    = ST_IDLE;
                    timer_next  = '0;
                    moved_next  = 1'b1;
                end else if (seq_reg != ST_IDLE) begin
                    if (timer_reg != '0) begin
                        timer_next = timer_reg - 1'b1;
                    end else begin
                        seq_next   = ST_IDLE;
                        timer_next = '0;
                    end
                end
            end
            CMD_BTN1: begin
                b1_press_next = !b1_press_reg;
                if (b1_press_reg && s_data.pin_level == LEVEL_PRESSED) begin
                    if (seq_reg == ST_IDLE) begin
                        seq_next   = ST_B1_DOWN;
                        timer_next = timeout_ticks_reg;
                    end else if (seq_reg == ST_B2_UP) begin
                        seq_next = ST_B1_DOWN_AGAIN;
                    end else begin
                        seq_next   = ST_IDLE;
                        timer_next = '0;
                    end
                end else if (!b1_press_reg && s_data.pin_level == LEVEL_RELEASED) begin
                    if (seq_reg == ST_B1_DOWN) begin
                        seq_next = ST_B1_UP;
                    end else if (seq_reg == ST_B1_DOWN_AGAIN) begin
                        seq_next = ST_COMPLETE;
                    end else begin
                        seq_next   = ST_IDLE;
                        timer_next = '0;
                    end
                end
            end
            CMD_BTN2: begin
                b2_press_next = !b2_press_reg;
                if (b2_press_reg && s_data.pin_level == LEVEL_PRESSED) begin
                    if (seq_reg == ST_B1_UP) begin
                        seq_next = ST_B2_DOWN;
                    end else begin
                        seq_next   = ST_IDLE;
                        timer_next = '0;
                    end
                end else if (!b2_press_reg && s_data.pin_level == LEVEL_RELEASED) begin
                    if (seq_reg == ST_B2_DOWN) begin
                        seq_next = ST_B2_UP;
                    end else begin
                        seq_next   = ST_IDLE;
                        timer_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // result
    always_comb begin
        m_data_next.pulse_width = at_max_next ? pulse_hi_reg : pulse_lo_reg;
        m_data_next.seq_state   = seq_next;
        m_data_next.moved       = moved_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= ST_IDLE;
            timer_reg    <= '0;
            at_max_reg   <= 1'b0;
            b1_press_reg <= 1'b1;
            b2_press_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                seq_reg      <= seq_next;
                timer_reg    <= timer_next;
                at_max_reg   <= at_max_next;
                b1_press_reg <= b1_press_next;
                b2_press_reg <= b2_press_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == ST_IDLE || seq_reg == ST_COMPLETE) |-> timer_reg == '0 ||
        seq_reg == ST_COMPLETE)
        else $error("timer running while idle");

    a_moved_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.moved) |-> m_data_reg.seq_state == ST_IDLE)
        else $error("moved reported without returning to idle");

    a_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == CMD_TICK && seq_reg == ST_COMPLETE)
        |=> at_max_reg != $past(at_max_reg))
        else $error("complete sequence did not toggle position");

    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted transaction produced no result");

    a_state_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.seq_state == seq_reg)
        else $error("result state differs from sequence register");

endmodule
